/* sv/range_reservation_table_assert.svh */
// ----------------------------------------------------------------------------
// range_reservation_table_assert.svh
// assertion macros shared by the range reservation table modules
// ----------------------------------------------------------------------------
`ifndef RANGE_RESERVATION_TABLE_ASSERT_SVH
`define RANGE_RESERVATION_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rrt_pkg.sv */
// ----------------------------------------------------------------------------
// rrt_pkg
// types, codes and sizes shared by the range reservation table modules
// ----------------------------------------------------------------------------
package rrt_pkg;

    // table size and derived widths
    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W:0] RD_END = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] USED_MAX = CNT_W'(TABLE_ENTRIES);

    // request commands
    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERLAP   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ZERO      = 3'd4
    } status_t;

    // one stored range: pool tag, first index, 65-bit last index
    typedef struct packed {
        logic [1:0]  pool;
        logic [63:0] first;
        logic [64:0] last;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

/* sv/rrt_ram.sv */
// ----------------------------------------------------------------------------
// rrt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/rrt_ctrl.sv */
// ----------------------------------------------------------------------------
// rrt_ctrl
// sequencer: accept a request, sweep the table, then resolve into the output
// ----------------------------------------------------------------------------
`include "range_reservation_table_assert.svh"

module rrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  rrt_pkg::dp_stat_t stat,
    output rrt_pkg::ctrl_cmd_t ctrl
);
    import rrt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_SCAN    = 3'b010,
        S_RESOLVE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        ctrl.load   = 1'b0;
        ctrl.scan   = 1'b0;
        ctrl.commit = 1'b0;
        req_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (stat.out_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `RRT_ASSERT_NEXT(a_load_starts_scan, ctrl.load, state_reg == S_SCAN, "load did not start a sweep")
    `RRT_ASSERT_NOW(a_commit_needs_room, ctrl.commit, stat.out_free, "commit with output still full")
    `RRT_ASSERT_NOW(a_stall_when_busy, state_reg != S_IDLE, req_stall, "request taken while busy")

endmodule

/* sv/rrt_dpath.sv */
// ----------------------------------------------------------------------------
// rrt_dpath
// request registers, table sweep with overlap and match compare, table
// update and result register
// ----------------------------------------------------------------------------
`include "range_reservation_table_assert.svh"

module rrt_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  rrt_pkg::ctrl_cmd_t ctrl,
    output rrt_pkg::dp_stat_t  stat,
    input  logic               cmd,
    input  logic [1:0]         pool,
    input  logic [63:0]        range_base,
    input  logic [32:0]        range_count,
    input  logic               rsp_stall,
    output logic               rsp_valid,
    output logic [2:0]         status,
    output logic [5:0]         entries_used
);
    import rrt_pkg::*;

    // request registers
    logic              req_cmd_reg,   req_cmd_next;
    logic [1:0]        req_pool_reg,  req_pool_next;
    logic [63:0]       req_first_reg, req_first_next;
    logic [64:0]       req_last_reg,  req_last_next;
    logic              req_zero_reg,  req_zero_next;

    // sweep state
    logic [IDX_W:0]    rd_cnt_reg,    rd_cnt_next;
    logic              cmp_vld_reg,   cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg,   cmp_idx_next;
    logic              hit_reg,       hit_next;
    logic [IDX_W-1:0]  hit_idx_reg,   hit_idx_next;
    logic              free_reg,      free_next;
    logic [IDX_W-1:0]  free_idx_reg,  free_idx_next;

    // table occupancy
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]  used_reg,      used_next;

    // result register
    logic              rsp_valid_reg, rsp_valid_next;
    logic [2:0]        status_reg,    status_next;
    logic [5:0]        used_out_reg,  used_out_next;

    // ram ports
    logic              wr_en;
    logic [ENTRY_W-1:0] wr_data;
    logic              rd_en;
    logic [ENTRY_W-1:0] rd_data;

    // compare and resolve signals
    entry_t            ent;
    entry_t            new_ent;
    logic              rd_issue;
    logic              ent_valid;
    logic              overlap;
    logic              exact;
    logic              cmp_match;
    logic              cmp_free;
    status_t           res_code;
    logic              tbl_set;
    logic              tbl_clr;
    logic [CNT_W-1:0]  used_commit;
    logic [CNT_W+5:0]  used_ext;

    rrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // sweep read issue
    assign rd_issue = (rd_cnt_reg != RD_END);
    assign rd_en    = ctrl.scan && rd_issue;

    // entry compare, one entry per cycle
    always_comb
    begin
        ent       = entry_t'(rd_data);
        ent_valid = valid_reg[cmp_idx_reg];
        overlap   = ({1'b0, req_first_reg} <= ent.last) &&
                    ({1'b0, ent.first} <= req_last_reg);
        exact     = (ent.first == req_first_reg) && (ent.last == req_last_reg);
        cmp_match = cmp_vld_reg && ent_valid && (ent.pool == req_pool_reg) &&
                    ((req_cmd_reg == CMD_ACQUIRE) ? overlap : exact);
        cmp_free  = cmp_vld_reg && !ent_valid;
    end

    // outcome of the request once the sweep is over
    always_comb
    begin
        res_code = ST_OK;
        tbl_set  = 1'b0;
        tbl_clr  = 1'b0;
        if (req_zero_reg)
        begin
            res_code = ST_ZERO;
        end
        else if (req_cmd_reg == CMD_ACQUIRE)
        begin
            if (hit_reg)
            begin
                res_code = ST_OVERLAP;
            end
            else if (!free_reg)
            begin
                res_code = ST_FULL;
            end
            else
            begin
                tbl_set = 1'b1;
            end
        end
        else
        begin
            if (hit_reg)
            begin
                tbl_clr = 1'b1;
            end
            else
            begin
                res_code = ST_NOT_FOUND;
            end
        end
    end

    // new entry written into the lowest free slot
    always_comb
    begin
        new_ent.pool  = req_pool_reg;
        new_ent.first = req_first_reg;
        new_ent.last  = req_last_reg;
        wr_data       = new_ent;
        wr_en         = ctrl.commit && tbl_set;
    end

    // occupancy after the request
    always_comb
    begin
        used_commit = used_reg;
        if (tbl_set)
        begin
            used_commit = used_reg + CNT_W'(1);
        end
        else if (tbl_clr)
        begin
            used_commit = used_reg - CNT_W'(1);
        end
        used_ext = {6'b0, used_commit};
    end

    // next values
    always_comb
    begin
        req_cmd_next   = req_cmd_reg;
        req_pool_next  = req_pool_reg;
        req_first_next = req_first_reg;
        req_last_next  = req_last_reg;
        req_zero_next  = req_zero_reg;
        rd_cnt_next    = rd_cnt_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        valid_next     = valid_reg;
        used_next      = used_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        used_out_next  = used_out_reg;

        // capture the request and rewind the sweep
        if (ctrl.load)
        begin
            req_cmd_next   = cmd;
            req_pool_next  = pool;
            req_first_next = range_base;
            req_last_next  = {1'b0, range_base} + {32'b0, range_count - 33'd1};
            req_zero_next  = (range_count == 33'd0);
            rd_cnt_next    = '0;
            cmp_vld_next   = 1'b0;
            hit_next       = 1'b0;
            free_next      = 1'b0;
        end

        // sweep: issue a read and compare the entry read last cycle
        if (ctrl.scan)
        begin
            if (rd_issue)
            begin
                rd_cnt_next = rd_cnt_reg + (IDX_W + 1)'(1);
            end
            cmp_vld_next = rd_issue;
            cmp_idx_next = rd_cnt_reg[IDX_W-1:0];
            if (cmp_match && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx_reg;
            end
            if (cmp_free && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx_reg;
            end
        end

        // output transfer taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // apply the outcome and load the result
        if (ctrl.commit)
        begin
            if (tbl_set)
            begin
                valid_next[free_idx_reg] = 1'b1;
            end
            if (tbl_clr)
            begin
                valid_next[hit_idx_reg] = 1'b0;
            end
            used_next      = used_commit;
            rsp_valid_next = 1'b1;
            status_next    = res_code;
            used_out_next  = used_ext[5:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            valid_reg     <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_cnt_reg    <= rd_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            valid_reg     <= valid_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_cmd_reg   <= req_cmd_next;
        req_pool_reg  <= req_pool_next;
        req_first_reg <= req_first_next;
        req_last_reg  <= req_last_next;
        req_zero_reg  <= req_zero_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        status_reg    <= status_next;
        used_out_reg  <= used_out_next;
    end

    // status to the controller and outputs
    assign stat.scan_done = !rd_issue && !cmp_vld_reg;
    assign stat.out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign entries_used   = used_out_reg;

    `RRT_ASSERT_NOW(a_used_bounded, 1'b1, used_reg <= USED_MAX, "occupancy above table size")
    `RRT_ASSERT_NOW(a_used_matches, 1'b1, used_reg == $countones(valid_reg), "occupancy out of step")
    `RRT_ASSERT_NOW(a_write_free_slot, wr_en, !valid_reg[free_idx_reg], "write over a live entry")
    `RRT_ASSERT_NEXT(a_commit_shows, ctrl.commit, rsp_valid_reg, "result not presented")

endmodule

/* sv/range_reservation_table.sv */
// ----------------------------------------------------------------------------
// range_reservation_table
// table of reserved index ranges, each tagged with a pool; acquire and
// release requests return a status and the table occupancy
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall): cmd, pool, range_base, range_count.
// An acquire stores the inclusive range unless it overlaps a stored range of
// the same pool or the table is full; a release removes an exact match.
// Response channel (rsp_valid/rsp_stall): status and entries_used, one
// response transfer per request transfer, in order.
// Each request sweeps every table entry through one ram read port, one entry
// a cycle: the reads, then a drain of the last compare, then a resolve step
// that loads the result into the output register. A request is not taken
// while another is being swept or resolved; the next one is taken only
// once the result of the last has entered the output register.
// The result sits in an output register: a new request is taken while it is
// stalled, but its own result waits until the register has been emptied.
// req_stall is high whenever a request is in progress.
// Reset empties the table at once (entry valid bits clear) and drops any
// pending result; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module range_reservation_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        cmd,
    input  logic [1:0]  pool,
    input  logic [63:0] range_base,
    input  logic [32:0] range_count,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [5:0]  entries_used
);
    import rrt_pkg::*;

    ctrl_cmd_t ctrl;
    dp_stat_t  stat;

    // sequencer
    rrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // table and compare datapath
    rrt_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .cmd          (cmd),
        .pool         (pool),
        .range_base   (range_base),
        .range_count  (range_count),
        .rsp_stall    (rsp_stall),
        .rsp_valid    (rsp_valid),
        .status       (status),
        .entries_used (entries_used)
    );

endmodule

/* dv/range_reservation_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_reservation_table_test
// Self-checking bench for the range reservation table. A queue of requests,
// directed first and then random (fill and drain phases with well-formed
// acquire/release pairs plus noise), is fed through the request channel.
// Every request transfer updates a local copy of the table, and the status
// and occupancy it predicts are compared with each response transfer.
// ----------------------------------------------------------------------------
module range_reservation_table_test;

    import rrt_pkg::*;

    localparam int IDLE_PCT     = 28;
    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASE_LEN    = 150;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 160;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 4 * (TABLE_ENTRIES + 2);
    localparam logic [32:0] COUNT_MAX = 33'h1_0000_0000;
    localparam logic [63:0] BASE_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;

    // one request as queued for the driver
    typedef struct {
        cmd_t        cmd;
        logic [1:0]  pool;
        logic [63:0] base;
        logic [32:0] count;
        bit          calm;
        bit          drain_first;
    } range_req_t;

    // one predicted response
    typedef struct {
        status_t    status;
        logic [5:0] used;
    } range_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        cmd = CMD_ACQUIRE;
    logic [1:0]  pool = '0;
    logic [63:0] range_base = '0;
    logic [32:0] range_count = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [2:0]  status;
    logic [5:0]  entries_used;

    range_req_t pending_q[$];
    range_req_t held_q[$];
    range_rsp_t rsp_expect_q[$];

    // local copy of the table
    bit          tbl_valid [TABLE_ENTRIES];
    logic [1:0]  tbl_pool  [TABLE_ENTRIES];
    logic [63:0] tbl_first [TABLE_ENTRIES];
    logic [64:0] tbl_last  [TABLE_ENTRIES];

    bit cur_taken = 1'b0;
    bit calm_now = 1'b0;
    bit hold_started = 1'b0;
    int hold_left = 0;
    int req_xfers = 0;
    int quiet_cycles = 0;
    int errors = 0;

    range_reservation_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .cmd          (cmd),
        .pool         (pool),
        .range_base   (range_base),
        .range_count  (range_count),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .entries_used (entries_used)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // apply one request to the local table and give the response it causes
    task automatic reserve_or_release(input range_req_t rq, output range_rsp_t rs);
        logic [64:0] last;
        int          free_idx;
        int          used;
        int          i;
        bit          found;
        rs.status = ST_OK;
        if (rq.count == '0)
        begin
            rs.status = ST_ZERO;
        end
        else
        begin
            last = {1'b0, rq.base} + 65'(rq.count - 33'd1);
            if (rq.cmd == CMD_ACQUIRE)
            begin
                free_idx = -1;
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!tbl_valid[i])
                    begin
                        if (free_idx < 0)
                            free_idx = i;
                    end
                    else if (tbl_pool[i] == rq.pool && {1'b0, rq.base} <= tbl_last[i]
                             && {1'b0, tbl_first[i]} <= last)
                    begin
                        rs.status = ST_OVERLAP;
                    end
                end
                if (rs.status == ST_OK)
                begin
                    if (free_idx < 0)
                        rs.status = ST_FULL;
                    else
                    begin
                        tbl_valid[free_idx] = 1'b1;
                        tbl_pool[free_idx]  = rq.pool;
                        tbl_first[free_idx] = rq.base;
                        tbl_last[free_idx]  = last;
                    end
                end
            end
            else
            begin
                // exact match of pool, first and last, lowest entry wins
                found = 1'b0;
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!found && tbl_valid[i] && tbl_pool[i] == rq.pool
                        && tbl_first[i] == rq.base && tbl_last[i] == last)
                    begin
                        tbl_valid[i] = 1'b0;
                        found = 1'b1;
                    end
                end
                rs.status = found ? ST_OK : ST_NOT_FOUND;
            end
        end
        used = 0;
        for (i = 0; i < TABLE_ENTRIES; i++)
            used += tbl_valid[i];
        rs.used = 6'(used);
    endtask

    function automatic range_req_t make_req(cmd_t c, logic [1:0] p, logic [63:0] b,
                                            logic [32:0] n);
        range_req_t rq;
        rq.cmd = c;
        rq.pool = p;
        rq.base = b;
        rq.count = n;
        rq.calm = 1'b0;
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    function automatic logic [1:0] pick_pool();
        return ($urandom_range(0, 99) < 5) ? 2'd3 : 2'($urandom_range(0, 2));
    endfunction

    function automatic logic [32:0] pick_wide_count();
        return ($urandom_range(0, 9) == 0) ? COUNT_MAX : {1'b0, 32'($urandom)};
    endfunction

    // random request; filling phases lean to acquires, draining to releases
    function automatic range_req_t make_random_req(bit filling);
        range_req_t rq;
        logic [63:0] window;
        int          k;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 20 : 65))
        begin
            if (held_q.size() > 0 && $urandom_range(0, 99) < 80)
            begin
                k = $urandom_range(0, held_q.size() - 1);
                rq = held_q[k];
                held_q.delete(k);
                rq.cmd = CMD_RELEASE;
            end
            else
            begin
                // broken release: near miss of a held range, or pure noise
                if (held_q.size() > 0)
                    rq = held_q[$urandom_range(0, held_q.size() - 1)];
                else
                    rq = make_req(CMD_RELEASE, pick_pool(), {$urandom, $urandom},
                                  pick_wide_count());
                rq.cmd = CMD_RELEASE;
                case ($urandom_range(0, 2))
                    0: rq.count = (rq.count == COUNT_MAX) ? rq.count - 33'd1
                                                          : rq.count + 33'd1;
                    1: rq.base = rq.base ^ 64'd1;
                    default: rq.pool = rq.pool + 2'd1;
                endcase
            end
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                case ($urandom_range(0, 2))
                    0: window = 64'd0;
                    1: window = 64'h0000_0000_1000_0000;
                    default: window = 64'hFFFF_FFFF_FFFF_F000;
                endcase
                rq = make_req(CMD_ACQUIRE, pick_pool(), window + $urandom_range(0, 1023),
                              33'($urandom_range(1, 64)));
            end
            else if (roll < 80)
                rq = make_req(CMD_ACQUIRE, pick_pool(), {$urandom, $urandom},
                              pick_wide_count());
            else if (roll < 92)
            begin
                // ranges that run past the top index
                rq = make_req(CMD_ACQUIRE, pick_pool(), BASE_MAX - $urandom_range(0, 255),
                              ($urandom_range(0, 3) == 0) ? COUNT_MAX
                                                           : 33'($urandom_range(1, 4096)));
            end
            else
                rq = make_req(cmd_t'($urandom_range(0, 1)), pick_pool(),
                              {$urandom, $urandom}, '0);
            if (rq.cmd == CMD_ACQUIRE && rq.count != '0)
            begin
                held_q.push_back(rq);
                if (held_q.size() > 48)
                    void'(held_q.pop_front());
            end
        end
        rq.calm = 1'b0;
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    // stimulus and end of run
    initial
    begin
        range_req_t rq;
        int         n;
        // zero count, overlap, pools, pool three, top crossing, exact release
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd0, 64'd0, 33'd0));
        pending_q.push_back(make_req(CMD_RELEASE, 2'd1, 64'd5, 33'd0));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd0, 64'd0, 33'd1));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd0, 64'd0, 33'd1));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd1, 64'd0, 33'd1));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd3, 64'd0, 33'd1));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd0, 64'd1, COUNT_MAX));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd0, 64'h1_0000_0000, 33'd1));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd2, BASE_MAX, COUNT_MAX));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd2, BASE_MAX, 33'd1));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd2, BASE_MAX - 64'd1, 33'd1));
        pending_q.push_back(make_req(CMD_RELEASE, 2'd2, BASE_MAX, 33'd1));
        pending_q.push_back(make_req(CMD_RELEASE, 2'd2, BASE_MAX, COUNT_MAX));
        pending_q.push_back(make_req(CMD_RELEASE, 2'd3, 64'd0, 33'd1));
        pending_q.push_back(make_req(CMD_RELEASE, 2'd0, 64'd0, 33'd2));
        pending_q.push_back(make_req(CMD_RELEASE, 2'd1, 64'd0, 33'd1));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd1, 64'h8000_0000_0000_0000,
                                     33'h0_FFFF_FFFF));
        pending_q.push_back(make_req(CMD_RELEASE, 2'd0, 64'd1, COUNT_MAX));
        pending_q.push_back(make_req(CMD_ACQUIRE, 2'd3, BASE_MAX, COUNT_MAX));
        pending_q.push_back(make_req(CMD_RELEASE, 2'd0, 64'd0, 33'd1));

        // random part in alternating fill and drain phases
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            rq = make_random_req(((n / PHASE_LEN) % 2) == 0);
            rq.calm = (n >= 700 && n < 900);
            rq.drain_first = (n == 0 || n == 1200);
            pending_q.push_back(rq);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() != 0 || req_valid || rsp_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // request driver: holds a stalled transfer, otherwise idles or offers the next
    always @(negedge clk)
    begin
        bit         offer;
        range_req_t rq;
        if (rst_n && !(req_valid && !cur_taken))
        begin
            offer = 1'b0;
            if (pending_q.size() != 0
                && !(pending_q[0].drain_first && rsp_expect_q.size() != 0)
                && (pending_q[0].calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                rq = pending_q.pop_front();
                offer = 1'b1;
                cmd <= rq.cmd;
                pool <= rq.pool;
                range_base <= rq.base;
                range_count <= rq.count;
                calm_now <= rq.calm;
            end
            req_valid <= offer;
        end
    end

    // response side stall, with one long hold-off once the run is under way
    always @(negedge clk)
    begin
        bit nxt;
        if (!hold_started && req_xfers >= HOLD_AT)
        begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            nxt = 1'b1;
            hold_left--;
        end
        else
            nxt = !calm_now && ($urandom_range(0, 99) < IDLE_PCT);
        rsp_stall <= nxt;
    end

    // monitor: predict on request transfers, check on response transfers
    always @(posedge clk)
    begin
        range_req_t rq;
        range_rsp_t rs;
        bit         req_xfer;
        bit         rsp_xfer;
        req_xfer = rst_n && req_valid && !req_stall;
        rsp_xfer = rst_n && rsp_valid && !rsp_stall;
        cur_taken <= req_xfer;
        if (rsp_xfer)
        begin
            if (rsp_expect_q.size() == 0)
                report_mismatch("response transfer with no request outstanding");
            else
            begin
                rs = rsp_expect_q.pop_front();
                if (status !== rs.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              status, rs.status));
                if (entries_used !== rs.used)
                    report_mismatch($sformatf("entries_used %0d, predicted %0d",
                                              entries_used, rs.used));
            end
        end
        if (req_xfer)
        begin
            rq = make_req(cmd_t'(cmd), pool, range_base, range_count);
            reserve_or_release(rq, rs);
            rsp_expect_q.push_back(rs);
            req_xfers <= req_xfers + 1;
        end
        // watchdog on cycles with no transfer at all
        if (req_xfer || rsp_xfer)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

/* filelist.f */
+incdir+sv
sv/rrt_pkg.sv
sv/rrt_ram.sv
sv/rrt_ctrl.sv
sv/rrt_dpath.sv
sv/range_reservation_table.sv
dv/range_reservation_table_test.sv
